// File: hdl/ogru_pkg.sv
package ogru_pkg;

  // Grid window half-width and input coordinate format
  localparam int GRID_HALF       = 127;
  localparam int COORD_FRAC_BITS = 16;

  // Largest usable index limit: every accepted cell lies inside the window
  localparam int          LIM_CAP_INT = (GRID_HALF < 127) ? GRID_HALF : 127;
  localparam logic [6:0]  LIM_CAP     = 7'(LIM_CAP_INT);
  localparam logic signed [12:0] GRID_HALF_S = 13'(GRID_HALF);

  // Scaling: |point| * cells_per_meter carries COORD_FRAC_BITS + 8 fraction bits
  localparam int          PROD_W    = 48;
  localparam int          RND_SHIFT = COORD_FRAC_BITS + 8;
  localparam logic [48:0] RND_HALF  = 49'd1 << (COORD_FRAC_BITS + 7);

  // Cell store addressed by {row, column} in 8-bit two's complement
  localparam int ADDR_W = 16;

  typedef logic [1:0] cell_t;
  localparam cell_t CELL_UNKNOWN  = 2'd0;
  localparam cell_t CELL_FREE     = 2'd1;
  localparam cell_t CELL_OCCUPIED = 2'd2;

  typedef logic [1:0] status_t;
  localparam status_t ST_INSERTED  = 2'd0;
  localparam status_t ST_REJECTED  = 2'd1;
  localparam status_t ST_READ_DONE = 2'd2;

  // Configuration register indexes
  localparam logic CFG_CELLS_PER_METER = 1'b0;
  localparam logic CFG_RANGE_LIMIT     = 1'b1;

  // Item kinds
  localparam logic KIND_INSERT = 1'b0;
  localparam logic KIND_READ   = 1'b1;

  // One scaled coordinate
  typedef struct packed {
    logic              ok;
    logic signed [7:0] cell_idx;
  } scale_res_t;

endpackage

// File: hdl/ogru_scale.sv
module ogru_scale import ogru_pkg::*; (
  input  logic               clk_i,
  input  logic signed [31:0] coord_i,
  input  logic [15:0]        cells_per_meter_i,
  input  logic [6:0]         lim_i,
  output scale_res_t         res_o
);

  logic              neg;
  logic [31:0]       mag;
  logic [PROD_W-1:0] prod_d;
  logic [PROD_W-1:0] prod_q;
  logic              neg_q;
  logic [48:0]       rnd_sum;
  logic [48:0]       cell_mag;

  // Take the magnitude and multiply by the scale
  assign neg    = coord_i[31];
  assign mag    = neg ? (~coord_i + 32'd1) : coord_i;
  assign prod_d = {16'd0, mag} * {32'd0, cells_per_meter_i};

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    neg_q  <= neg;
  end

  // Round half away from zero, check the limit, restore the sign
  assign rnd_sum  = {1'b0, prod_q} + RND_HALF;
  assign cell_mag = rnd_sum >> RND_SHIFT;

  assign res_o.ok       = (cell_mag <= {42'd0, lim_i});
  assign res_o.cell_idx = neg_q ? 8'(8'd0 - cell_mag[7:0]) : cell_mag[7:0];

endmodule

// File: hdl/occupancy_grid_ray_update.sv
// Insert: the ray walk reads one cell and writes back the previous one each cycle on the grid RAM.
// One item at a time; the next item is taken once the result sits in the output register.
// Reset: box and configuration return to defaults, then a clearing pass writes every
//   grid entry to unknown before the first item is taken.
module occupancy_grid_ray_update import ogru_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  // configuration
  input  logic               cfg_we_i,
  input  logic               cfg_idx_i,
  input  logic [15:0]        cfg_wdata_i,
  // input items
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               kind_i,
  input  logic signed [31:0] point_x_i,
  input  logic signed [31:0] point_y_i,
  input  logic signed [7:0]  query_x_i,
  input  logic signed [7:0]  query_y_i,
  // results
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [1:0]         status_o,
  output logic [1:0]         cell_state_o,
  output logic signed [7:0]  box_min_x_o,
  output logic [6:0]         box_max_x_o,
  output logic signed [7:0]  box_min_y_o,
  output logic [6:0]         box_max_y_o
);

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_MUL_X, S_RND_X, S_RND_Y, S_DECIDE,
    S_WALK, S_MARK, S_READ, S_READ_WAIT, S_DONE
  } state_e;

  state_e state_q;

  // Configuration
  logic [15:0] cpm_q;
  logic [6:0]  rlim_q;
  logic [6:0]  lim;

  // Item and walk registers
  logic signed [31:0] px_q, py_q;
  logic signed [7:0]  qx_q, qy_q;
  logic signed [7:0]  cx_q, cy_q;
  logic               okx_q, oky_q;
  logic signed [7:0]  x_q, y_q;
  logic [6:0]         dx_q, dy_q;
  logic               sx_q, sy_q;
  logic signed [9:0]  err_q;
  logic               pend_v_q;
  logic [ADDR_W-1:0]  pend_addr_q;
  logic [ADDR_W-1:0]  clr_cnt_q;

  // Box
  logic signed [7:0] low_x_q, high_x_q, low_y_q, high_y_q;

  // Result staging and output register
  status_t res_status_q;
  cell_t   res_cell_q;
  logic    out_valid_q;
  status_t out_status_q;
  cell_t   out_cell_q;
  logic signed [7:0] out_min_x_q, out_min_y_q;
  logic [6:0]        out_max_x_q, out_max_y_q;

  // Grid RAM
  cell_t             grid_mem_q [0:(1 << ADDR_W) - 1];
  cell_t             rdata_q;
  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic [ADDR_W-1:0] mem_raddr;
  cell_t             mem_wdata;

  // Shared scaling unit
  logic signed [31:0] scale_coord;
  scale_res_t         scale_res;

  // Walk datapath
  logic               at_end;
  logic signed [10:0] e2;
  logic               step_x, step_y;
  logic signed [9:0]  err_next;
  logic signed [7:0]  abs_cx, abs_cy;
  logic signed [12:0] qx_ext, qy_ext;
  logic               query_in_win;
  logic               out_free;

  assign lim = (rlim_q < LIM_CAP) ? rlim_q : LIM_CAP;

  assign scale_coord = (state_q == S_MUL_X) ? px_q : py_q;

  ogru_scale u_scale (
    .clk_i             (clk_i),
    .coord_i           (scale_coord),
    .cells_per_meter_i (cpm_q),
    .lim_i             (lim),
    .res_o             (scale_res)
  );

  // Bresenham step decision
  assign at_end   = (x_q == cx_q) && (y_q == cy_q);
  assign e2       = {err_q[9], err_q} <<< 1;
  assign step_x   = e2 > -$signed({4'd0, dy_q});
  assign step_y   = e2 < $signed({4'd0, dx_q});
  assign err_next = err_q - (step_x ? $signed({3'd0, dy_q}) : 10'sd0)
                          + (step_y ? $signed({3'd0, dx_q}) : 10'sd0);

  assign abs_cx = cx_q[7] ? 8'(8'd0 - cx_q) : cx_q;
  assign abs_cy = cy_q[7] ? 8'(8'd0 - cy_q) : cy_q;

  // Query window check
  assign qx_ext       = 13'(qx_q);
  assign qy_ext       = 13'(qy_q);
  assign query_in_win = (qx_ext <= GRID_HALF_S) && (qx_ext >= -GRID_HALF_S) &&
                        (qy_ext <= GRID_HALF_S) && (qy_ext >= -GRID_HALF_S);

  assign out_free = !out_valid_q || out_ready_i;

  // Grid RAM port control
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = pend_addr_q;
    mem_wdata = (rdata_q == CELL_OCCUPIED) ? CELL_OCCUPIED : CELL_FREE;
    mem_raddr = {y_q, x_q};
    unique case (state_q)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_cnt_q;
        mem_wdata = CELL_UNKNOWN;
      end
      S_WALK: mem_we = pend_v_q;
      S_MARK: begin
        mem_we    = 1'b1;
        mem_waddr = {cy_q, cx_q};
        mem_wdata = CELL_OCCUPIED;
      end
      S_READ: mem_raddr = {qy_q, qx_q};
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      grid_mem_q[mem_waddr] <= mem_wdata;
    end
    rdata_q <= grid_mem_q[mem_raddr];
  end

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cpm_q  <= 16'd5120;
      rlim_q <= 7'd127;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_CELLS_PER_METER: cpm_q  <= cfg_wdata_i;
        CFG_RANGE_LIMIT:     rlim_q <= cfg_wdata_i[6:0];
      endcase
    end
  end

  // Sequencer, box and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_cnt_q   <= '0;
      pend_v_q    <= 1'b0;
      out_valid_q <= 1'b0;
      low_x_q     <= '0;
      high_x_q    <= '0;
      low_y_q     <= '0;
      high_y_q    <= '0;
    end else begin
      // raise the result once staged, drop it once taken
      if (state_q == S_DONE && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_CLEAR: begin
          clr_cnt_q <= clr_cnt_q + 1'b1;
          if (clr_cnt_q == '1) begin
            state_q <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_valid_i) begin
            state_q <= (kind_i == KIND_READ) ? S_READ : S_MUL_X;
          end
        end
        S_MUL_X: state_q <= S_RND_X;
        S_RND_X: state_q <= S_RND_Y;
        S_RND_Y: state_q <= S_DECIDE;
        S_DECIDE: begin
          if (okx_q && oky_q) begin
            if (cx_q < low_x_q)  low_x_q  <= cx_q;
            if (cx_q > high_x_q) high_x_q <= cx_q;
            if (cy_q < low_y_q)  low_y_q  <= cy_q;
            if (cy_q > high_y_q) high_y_q <= cy_q;
            pend_v_q <= 1'b0;
            state_q  <= S_WALK;
          end else begin
            state_q <= S_DONE;
          end
        end
        S_WALK: begin
          // finish the pending write-back, then mark the end cell
          if (at_end) begin
            pend_v_q <= 1'b0;
            state_q  <= S_MARK;
          end else begin
            pend_v_q <= 1'b1;
          end
        end
        S_MARK:      state_q <= S_DONE;
        S_READ:      state_q <= S_READ_WAIT;
        S_READ_WAIT: state_q <= S_DONE;
        S_DONE: begin
          if (out_free) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      S_IDLE: begin
        px_q   <= point_x_i;
        py_q   <= point_y_i;
        qx_q   <= query_x_i;
        qy_q   <= query_y_i;
      end
      S_RND_X: begin
        okx_q <= scale_res.ok;
        cx_q  <= scale_res.cell_idx;
      end
      S_RND_Y: begin
        oky_q <= scale_res.ok;
        cy_q  <= scale_res.cell_idx;
      end
      S_DECIDE: begin
        x_q          <= '0;
        y_q          <= '0;
        dx_q         <= abs_cx[6:0];
        dy_q         <= abs_cy[6:0];
        sx_q         <= (cx_q > 8'sd0);
        sy_q         <= (cy_q > 8'sd0);
        err_q        <= $signed({3'd0, abs_cx[6:0]}) - $signed({3'd0, abs_cy[6:0]});
        res_cell_q   <= CELL_UNKNOWN;
        res_status_q <= (okx_q && oky_q) ? ST_INSERTED : ST_REJECTED;
      end
      S_WALK: begin
        // advance one cell and remember the one just read
        if (!at_end) begin
          pend_addr_q <= {y_q, x_q};
          err_q       <= err_next;
          if (step_x) x_q <= sx_q ? 8'(x_q + 8'sd1) : 8'(x_q - 8'sd1);
          if (step_y) y_q <= sy_q ? 8'(y_q + 8'sd1) : 8'(y_q - 8'sd1);
        end
      end
      S_READ_WAIT: begin
        res_cell_q   <= query_in_win ? rdata_q : CELL_UNKNOWN;
        res_status_q <= ST_READ_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          out_status_q <= res_status_q;
          out_cell_q   <= res_cell_q;
          out_min_x_q  <= low_x_q;
          out_max_x_q  <= high_x_q[6:0];
          out_min_y_q  <= low_y_q;
          out_max_y_q  <= high_y_q[6:0];
        end
      end
      default: ;
    endcase
  end

  assign in_ready_o   = (state_q == S_IDLE);
  assign out_valid_o  = out_valid_q;
  assign status_o     = out_status_q;
  assign cell_state_o = out_cell_q;
  assign box_min_x_o  = out_min_x_q;
  assign box_max_x_o  = out_max_x_q;
  assign box_min_y_o  = out_min_y_q;
  assign box_max_y_o  = out_max_y_q;

endmodule

// File: verif/tb_occupancy_grid_ray_update.sv
`timescale 1ns / 100ps

module tb_occupancy_grid_ray_update;
  import ogru_pkg::*;

  localparam int CYCLE_LIMIT  = 2_000_000;
  localparam int GAP_MAX      = 14;
  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_CYCLES = 200;
  localparam int PHASE_ITEMS  = 270;

  typedef struct packed {
    status_t     status;
    cell_t       cell_state;
    logic [7:0]  min_x;
    logic [6:0]  max_x;
    logic [7:0]  min_y;
    logic [6:0]  max_y;
  } grid_result_t;

  logic               clk;
  logic               rst_n;
  logic               cfg_we;
  logic               cfg_idx;
  logic [15:0]        cfg_wdata;
  logic               in_valid;
  logic               in_ready;
  logic               kind;
  logic signed [31:0] point_x;
  logic signed [31:0] point_y;
  logic signed [7:0]  query_x;
  logic signed [7:0]  query_y;
  logic               out_valid;
  logic               out_ready;
  logic [1:0]         status;
  logic [1:0]         cell_state;
  logic signed [7:0]  box_min_x;
  logic [6:0]         box_max_x;
  logic signed [7:0]  box_min_y;
  logic [6:0]         box_max_y;

  // Shadow of the grid, the box and the registers
  cell_t        grid_map [-GRID_HALF:GRID_HALF][-GRID_HALF:GRID_HALF];
  int           low_x, high_x, low_y, high_y;
  logic [15:0]  cpm_cfg;
  logic [6:0]   rlim_cfg;

  grid_result_t pending_results[$];
  int           errors;
  int           cycle_count;
  bit           gap_on;
  bit           stall_on;
  bit           hold_req;

  occupancy_grid_ray_update dut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_wdata_i  (cfg_wdata),
    .in_valid_i   (in_valid),
    .in_ready_o   (in_ready),
    .kind_i       (kind),
    .point_x_i    (point_x),
    .point_y_i    (point_y),
    .query_x_i    (query_x),
    .query_y_i    (query_y),
    .out_valid_o  (out_valid),
    .out_ready_i  (out_ready),
    .status_o     (status),
    .cell_state_o (cell_state),
    .box_min_x_o  (box_min_x),
    .box_max_x_o  (box_max_x),
    .box_min_y_o  (box_min_y),
    .box_max_y_o  (box_max_y)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Abort a hung run
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("tb_occupancy_grid_ray_update NOT OK");
    $finish;
  end

  // Scale one Q16.16 coordinate to a cell index, rounding half away from zero
  function automatic bit scale_to_cell(input logic [31:0] raw, input int lim,
                                       output int cell_idx);
    longint unsigned mag;
    longint unsigned q;
    mag = raw[31] ? (64'h1_0000_0000 - {32'b0, raw}) : {32'b0, raw};
    q = (mag * longint'(cpm_cfg) + (64'd1 << (COORD_FRAC_BITS + 7)))
        >> (COORD_FRAC_BITS + 8);
    if (q > longint'(lim)) return 1'b0;
    cell_idx = raw[31] ? -int'(q) : int'(q);
    return 1'b1;
  endfunction

  // Walk the line from the origin, freeing unknown cells short of the end cell
  function automatic void cast_ray(input int x1, input int y1);
    int x, y, dx, dy, sx, sy, err, e2;
    x = 0;
    y = 0;
    dx = (x1 < 0) ? -x1 : x1;
    dy = (y1 < 0) ? -y1 : y1;
    sx = (x1 > 0) ? 1 : -1;
    sy = (y1 > 0) ? 1 : -1;
    err = dx - dy;
    while (x != x1 || y != y1) begin
      if (grid_map[y][x] == CELL_UNKNOWN) grid_map[y][x] = CELL_FREE;
      e2 = 2 * err;
      if (e2 > -dy) begin
        err -= dy;
        x += sx;
      end
      if (e2 < dx) begin
        err += dx;
        y += sy;
      end
    end
  endfunction

  // Apply one item to the shadow grid and return its result
  function automatic grid_result_t apply_item(input logic k, input logic [31:0] px,
                                              input logic [31:0] py,
                                              input logic [7:0] qx, input logic [7:0] qy);
    grid_result_t r;
    int lim, cx, cy, sqx, sqy;
    bit okx, oky;
    r = '0;
    cx = 0;
    cy = 0;
    if (k == KIND_INSERT) begin
      lim = (int'(rlim_cfg) < GRID_HALF) ? int'(rlim_cfg) : GRID_HALF;
      okx = scale_to_cell(px, lim, cx);
      oky = scale_to_cell(py, lim, cy);
      if (okx && oky) begin
        if (cx < low_x) low_x = cx;
        if (cx > high_x) high_x = cx;
        if (cy < low_y) low_y = cy;
        if (cy > high_y) high_y = cy;
        cast_ray(cx, cy);
        grid_map[cy][cx] = CELL_OCCUPIED;
        r.status = ST_INSERTED;
      end else begin
        r.status = ST_REJECTED;
      end
    end else begin
      sqx = int'($signed(qx));
      sqy = int'($signed(qy));
      if (sqx >= -GRID_HALF && sqx <= GRID_HALF && sqy >= -GRID_HALF && sqy <= GRID_HALF)
        r.cell_state = grid_map[sqy][sqx];
      r.status = ST_READ_DONE;
    end
    r.min_x = low_x[7:0];
    r.max_x = high_x[6:0];
    r.min_y = low_y[7:0];
    r.max_y = high_y[6:0];
    return r;
  endfunction

  // Point coordinate that lands on the given cell at the current scale
  function automatic logic [31:0] point_for_cell(input int c);
    longint num;
    num = longint'(c) * 64'sd16777216;
    num = (c >= 0) ? num + longint'(cpm_cfg) / 2 : num - longint'(cpm_cfg) / 2;
    return 32'(num / longint'(cpm_cfg));
  endfunction

  // Random coordinate whose cell magnitude stays within bound
  function automatic logic [31:0] pick_coord(input int bound);
    longint unsigned top;
    logic [31:0] mag;
    if (cpm_cfg == 16'd0) return $urandom();
    top = (longint'(2 * bound + 1) * 64'd8388608 - 1) / longint'(cpm_cfg);
    if (top > 64'd2147483647) top = 64'd2147483647;
    mag = $urandom_range(32'(top), 0);
    return $urandom_range(1, 0) ? -mag : mag;
  endfunction

  task automatic report_field(input string name, input int exp_v, input int act_v);
    if (exp_v != act_v) begin
      errors++;
      $display("%0t: %s mismatch: expected %0d, got %0d", $time, name, exp_v, act_v);
    end
  endtask

  // Compare each result transfer with the oldest prediction
  always @(posedge clk) begin : check_results
    grid_result_t exp_r;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        errors++;
        $display("%0t: result with no prediction pending: status %0d", $time, status);
      end else begin
        exp_r = pending_results.pop_front();
        report_field("status", exp_r.status, status);
        report_field("cell_state", exp_r.cell_state, cell_state);
        report_field("box_min_x", int'($signed(exp_r.min_x)), int'(box_min_x));
        report_field("box_max_x", exp_r.max_x, box_max_x);
        report_field("box_min_y", int'($signed(exp_r.min_y)), int'(box_min_y));
        report_field("box_max_y", exp_r.max_y, box_max_y);
      end
    end
  end

  // Result side: random stalls, plus one long hold-off on request
  initial begin : result_sink
    int stall;
    out_ready = 1'b0;
    forever begin
      stall = stall_on ? $urandom_range(GAP_MAX, 0) : 0;
      @(negedge clk);
      if (hold_req) begin
        out_ready <= 1'b0;
        hold_req = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end else if (stall != 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!(out_valid && out_ready));
    end
  end

  // Offer one item and record its prediction on transfer
  task automatic offer_item(input logic k, input logic [31:0] px, input logic [31:0] py,
                            input logic [7:0] qx, input logic [7:0] qy);
    int gap;
    gap = gap_on ? $urandom_range(GAP_MAX, 0) : 0;
    @(negedge clk);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    kind     <= k;
    point_x  <= px;
    point_y  <= py;
    query_x  <= qx;
    query_y  <= qy;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    pending_results.push_back(apply_item(k, px, py, qx, qy));
  endtask

  task automatic insert_cell(input int cx, input int cy);
    offer_item(KIND_INSERT, point_for_cell(cx), point_for_cell(cy), $urandom(), $urandom());
  endtask

  task automatic insert_raw(input logic [31:0] px, input logic [31:0] py);
    offer_item(KIND_INSERT, px, py, $urandom(), $urandom());
  endtask

  task automatic read_cell(input int qx, input int qy);
    offer_item(KIND_READ, $urandom(), $urandom(), 8'(qx), 8'(qy));
  endtask

  task automatic release_input();
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  // Write one register once every result is back
  task automatic write_reg(input logic idx, input logic [15:0] data);
    release_input();
    while (pending_results.size() != 0) @(posedge clk);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_CELLS_PER_METER) cpm_cfg = data;
    else rlim_cfg = data[6:0];
  endtask

  // Reset values: 20 cells per meter, full range
  task automatic test_reset_state();
    read_cell(0, 0);
    read_cell(-128, -128);
    insert_raw(32'd0, 32'd0);                 // end cell at the origin
    read_cell(0, 0);
    insert_cell(5, 0);
    insert_cell(GRID_HALF, 0);                // ray runs over an occupied cell
    read_cell(5, 0);
    read_cell(1, 0);
    insert_cell(-GRID_HALF, -GRID_HALF);
    insert_cell(-GRID_HALF, GRID_HALF);
    insert_cell(GRID_HALF + 1, 0);            // just past the limit
    insert_raw(point_for_cell(3), 32'h8000_0000);
    insert_raw(32'h7FFF_FFFF, 32'd0);
    read_cell(GRID_HALF, 0);
    read_cell(-GRID_HALF, GRID_HALF);
    read_cell(GRID_HALF, GRID_HALF);
  endtask

  // Rounding ties, zero scale, full scale, and a zero limit
  task automatic test_scaling_corners();
    write_reg(CFG_CELLS_PER_METER, 16'd256);
    insert_raw(32'h0000_8000, 32'hFFFF_8000);
    insert_raw(32'h0000_7FFF, 32'hFFFF_8001);
    read_cell(1, -1);
    write_reg(CFG_CELLS_PER_METER, 16'd0);
    insert_raw(32'h7FFF_FFFF, 32'h8000_0000);
    write_reg(CFG_CELLS_PER_METER, 16'hFFFF);
    write_reg(CFG_RANGE_LIMIT, 16'd0);
    insert_raw(32'h0000_0080, 32'd0);
    insert_raw(32'h0000_0081, 32'd0);
    write_reg(CFG_CELLS_PER_METER, 16'd1);
    write_reg(CFG_RANGE_LIMIT, 16'hFF7F);     // upper bits dropped
    insert_raw(32'h7FFF_FFFF, 32'h7F00_0000);
    insert_raw(32'h7F7F_FFFF, 32'h8080_0001);
    read_cell(GRID_HALF, -GRID_HALF);
  endtask

  // Stall the result side so that the block fills and holds off its input
  task automatic test_backpressure();
    write_reg(CFG_CELLS_PER_METER, 16'd5120);
    gap_on = 1'b0;
    hold_req = 1'b1;
    repeat (20) begin
      if ($urandom_range(1, 0)) insert_cell($urandom_range(20, 0) - 10, $urandom_range(20, 0) - 10);
      else read_cell($urandom_range(20, 0) - 10, $urandom_range(20, 0) - 10);
    end
    gap_on = 1'b1;
  endtask

  // Mostly in-range inserts and reads inside the box, some noise
  task automatic run_traffic(input int count);
    int pick, lim, bound;
    repeat (count) begin
      pick = $urandom_range(99, 0);
      lim = (int'(rlim_cfg) < GRID_HALF) ? int'(rlim_cfg) : GRID_HALF;
      bound = ($urandom_range(1, 0) || lim < 12) ? lim : 12;
      if (pick < 55)
        insert_raw(pick_coord(bound), pick_coord(bound));
      else if (pick < 65)
        insert_raw($urandom(), $urandom());
      else if (pick < 90)
        read_cell(low_x + $urandom_range(high_x - low_x, 0),
                  low_y + $urandom_range(high_y - low_y, 0));
      else
        read_cell($urandom_range(255, 0), $urandom_range(255, 0));
    end
  endtask

  task automatic test_random_traffic();
    logic [15:0] cpm_v;
    logic [6:0]  lim_v;
    for (int p = 0; p < 6; p++) begin
      case (p)
        0: begin cpm_v = 16'd5120; lim_v = 7'd127; end
        1: begin cpm_v = 16'd256;  lim_v = 7'($urandom_range(127, 0)); end
        2: begin cpm_v = 16'hFFFF; lim_v = 7'd127; end
        3: begin cpm_v = 16'($urandom_range(65535, 1)); lim_v = 7'($urandom_range(127, 0)); end
        4: begin cpm_v = 16'd1;    lim_v = 7'd127; end
        default: begin cpm_v = 16'd768; lim_v = 7'd0; end
      endcase
      write_reg(CFG_CELLS_PER_METER, cpm_v);
      write_reg(CFG_RANGE_LIMIT, {9'($urandom()), lim_v});
      // every third phase runs with no idling at all, the others with random gaps and stalls
      gap_on   = (p % 3) != 1;
      stall_on = (p % 3) != 1;
      run_traffic(PHASE_ITEMS);
    end
    gap_on   = 1'b1;
    stall_on = 1'b1;
  endtask

  initial begin
    rst_n     = 1'b0;
    cfg_we    = 1'b0;
    cfg_idx   = CFG_CELLS_PER_METER;
    cfg_wdata = 16'd0;
    in_valid  = 1'b0;
    kind      = KIND_INSERT;
    point_x   = '0;
    point_y   = '0;
    query_x   = '0;
    query_y   = '0;
    errors    = 0;
    gap_on    = 1'b1;
    stall_on  = 1'b1;
    hold_req  = 1'b0;
    cpm_cfg   = 16'd5120;
    rlim_cfg  = 7'd127;
    low_x = 0; high_x = 0; low_y = 0; high_y = 0;
    for (int y = -GRID_HALF; y <= GRID_HALF; y++)
      for (int x = -GRID_HALF; x <= GRID_HALF; x++)
        grid_map[y][x] = CELL_UNKNOWN;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_reset_state();
    test_scaling_corners();
    test_backpressure();
    test_random_traffic();

    // Drain, then watch for stray results
    release_input();
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("tb_occupancy_grid_ray_update OK");
    end else begin
      $display("tb_occupancy_grid_ray_update NOT OK");
    end
    $finish;
  end

endmodule
